// File: sv/vehicle_command_generator_assert.svh
// assertion macros for the vehicle command generator
// used by files that carry concurrent checks
`ifndef VEHICLE_COMMAND_GENERATOR_ASSERT_SVH
`define VEHICLE_COMMAND_GENERATOR_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define VCG_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication checked outside reset
`define VCG_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: sv/vcg_pkg.sv
// package for the vehicle command generator
// holds widths, command codes and saturation helpers; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package vcg_pkg;
	localparam int POINTS_DEF = 16;
	localparam int FRAC_DEF   = 16;

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_PATH  = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;
	localparam logic [1:0] CMD_CLEAR = 2'd3;

	localparam logic [1:0] REG_MODE  = 2'd0;
	localparam logic [1:0] REG_SGAIN = 2'd1;
	localparam logic [1:0] REG_TGAIN = 2'd2;

	localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [31:0] row_time;
		logic signed [31:0] row_throttle;
		logic signed [31:0] row_braking;
		logic signed [31:0] row_steering;
		logic               path_has_pose;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic [15:0]        elapsed_seconds;
	} in_item_t;

	typedef struct packed {
		logic signed [17:0] steering;
		logic [16:0]        throttle;
		logic [16:0]        braking;
		logic               div_fault;
	} out_item_t;

	// saturating signed add
	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return s[64] ? S64_MIN : S64_MAX;
		return s[63:0];
	endfunction
endpackage
`default_nettype wire

// File: sv/vcg_stream_if.sv
// valid/ready channel carrying one payload type
// depends on nothing; payload type given by parameter
`timescale 1ns / 1ps
`default_nettype none
interface vcg_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: sv/vehicle_command_generator.sv
// vehicle command generator top level
// depends on vcg_pkg, vcg_stream_if, vcg_ram, vcg_divider and the assert header
// Usage:
//   in_ch carries one command per transaction: load row, path update, tick or
//   clear rows. out_ch carries one drive command per tick (none for the other
//   commands, none for a path-mode tick before the first path update).
//   Configuration goes through cfg_we/cfg_index/cfg_data while idle.
// Sequencing:
//   load, path and clear are taken while idle and can follow back to
//   back. A path-mode tick runs a division wait, then a multiply, before its
//   result is valid. A recorded-mode tick builds a weight for every loaded row:
//   one shared 64-bit divider runs serially for every weight step, one bit per
//   cycle; the weight products go through one shared 32x32 partial-product
//   multiplier. A zero divisor ends its division early.
// Reset: all control state clears, gains return to 1.0, mode to path mode,
//   no rows are loaded. Row memories are not cleared.
// Stall: a result waits in the output register; in_ch stays not ready
//   until it is taken.
`timescale 1ns / 1ps
`default_nettype none
module vehicle_command_generator #(
	parameter int POINTS    = vcg_pkg::POINTS_DEF,
	parameter int FRAC_BITS = vcg_pkg::FRAC_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	vcg_stream_if.sink       in_ch,
	vcg_stream_if.source     out_ch,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [23:0] cfg_data
);
	import vcg_pkg::*;
	`include "vehicle_command_generator_assert.svh"

	localparam int AW = (POINTS > 1) ? $clog2(POINTS) : 1;
	localparam int CW = $clog2(POINTS + 1);
	localparam logic signed [63:0] ONE_Q = 64'sd1 <<< FRAC_BITS;
	localparam logic signed [63:0] G055 = (55 * (64'sd1 <<< FRAC_BITS) + 50) / 100;

	typedef enum logic [4:0] {
		S_IDLE, S_PDIV, S_PWAIT, S_PMUL, S_IROW, S_IRD, S_ICHK, S_IMUL,
		S_IDIV, S_IDWAIT, S_INEXTJ, S_ARD, S_AMUL, S_AACC, S_FIN, S_OUT
	} state_t;

	state_t state_q;
	logic        mode_q;
	logic signed [23:0] sgain_q, tgain_q;
	logic [CW-1:0] rows_q;
	logic path_seen_q, pvalid_q;
	logic signed [31:0] sx_q, sy_q;
	logic signed [17:0] hsteer_q;
	logic [16:0] hbrake_q;
	logic fault_q;
	out_item_t out_q;
	logic out_valid_q;

	logic [CW-1:0] i_q, j_q;
	logic [1:0] ch_q;
	logic signed [63:0] w_q, ti_q, t_q, acc_t_q, acc_b_q, acc_s_q;

	// row memories
	logic [AW-1:0] raddr;
	logic [31:0] rd_t, rd_th, rd_b, rd_s;
	logic we_row;
	assign we_row = in_ch.valid && in_ch.ready && in_ch.payload.cmd == CMD_LOAD
		&& rows_q < CW'(POINTS);
	vcg_ram #(.WIDTH(32), .DEPTH(POINTS)) u_time (.clk(clk), .we(we_row),
		.waddr(rows_q[AW-1:0]), .wdata(in_ch.payload.row_time), .raddr(raddr), .rdata(rd_t));
	vcg_ram #(.WIDTH(32), .DEPTH(POINTS)) u_thr (.clk(clk), .we(we_row),
		.waddr(rows_q[AW-1:0]), .wdata(in_ch.payload.row_throttle), .raddr(raddr),
		.rdata(rd_th));
	vcg_ram #(.WIDTH(32), .DEPTH(POINTS)) u_brk (.clk(clk), .we(we_row),
		.waddr(rows_q[AW-1:0]), .wdata(in_ch.payload.row_braking), .raddr(raddr),
		.rdata(rd_b));
	vcg_ram #(.WIDTH(32), .DEPTH(POINTS)) u_str (.clk(clk), .we(we_row),
		.waddr(rows_q[AW-1:0]), .wdata(in_ch.payload.row_steering), .raddr(raddr),
		.rdata(rd_s));

	// shared divider
	logic div_start, div_busy, div_done, div_zero;
	logic signed [63:0] div_num, div_den, div_quo;
	vcg_divider u_div (.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(div_den), .busy(div_busy), .done(div_done), .quo(div_quo), .zero_div(div_zero));

	// shared saturating multiplier, partial products over cycles
	logic mul_start, mul_done;
	logic signed [63:0] mul_a, mul_b, mul_res;
	logic [63:0] ua_q, ub_q, mid_q;
	logic mneg_q, msat_q;
	logic [1:0] mstep_q;
	logic mbusy_q;
	logic [63:0] mp;
	logic [31:0] mpa, mpb;
	always_comb begin
		case (mstep_q)
			2'd0:    begin mpa = ua_q[63:32]; mpb = ub_q[31:0]; end
			2'd1:    begin mpa = ua_q[31:0]; mpb = ub_q[63:32]; end
			default: begin mpa = ua_q[31:0]; mpb = ub_q[31:0]; end
		endcase
	end
	assign mp = {32'd0, mpa} * {32'd0, mpb};
	logic [64:0] mid_sum;
	assign mid_sum = {1'b0, mid_q} + {1'b0, mp};
	logic [64:0] r_sum;
	assign r_sum = {1'b0, mp} + {1'b0, mid_q[31:0], 32'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q  <= 1'b0;
			mul_done <= 1'b0;
			mstep_q  <= '0;
			mneg_q   <= 1'b0;
			ua_q     <= '0;
			ub_q     <= '0;
			mid_q    <= '0;
			msat_q   <= 1'b0;
			mul_res  <= '0;
		end else begin
			mul_done <= 1'b0;
			if (mul_start) begin
				mbusy_q <= 1'b1;
				mstep_q <= 2'd0;
				mneg_q  <= mul_a[63] ^ mul_b[63];
				ua_q    <= mul_a[63] ? 64'(-mul_a) : 64'(mul_a);
				ub_q    <= mul_b[63] ? 64'(-mul_b) : 64'(mul_b);
				mid_q   <= '0;
				msat_q  <= 1'b0;
			end else if (mbusy_q) begin
				mstep_q <= mstep_q + 2'd1;
				case (mstep_q)
					2'd0: begin
						if (ua_q[63:32] != 0 && ub_q[63:32] != 0)
							msat_q <= 1'b1;
						mid_q <= mp;
					end
					2'd1: begin
						mid_q <= mid_sum[63:0];
						if (mid_sum[64] || mid_sum[63:32] != 0)
							msat_q <= 1'b1;
					end
					default: begin
						mbusy_q  <= 1'b0;
						mul_done <= 1'b1;
						if (ua_q == 0 || ub_q == 0)
							mul_res <= '0;
						else if (msat_q || r_sum[64])
							mul_res <= mneg_q ? S64_MIN : S64_MAX;
						else if (mneg_q)
							mul_res <= r_sum[63] ? S64_MIN : -$signed(r_sum[63:0]);
						else
							mul_res <= r_sum[63] ? S64_MAX : $signed(r_sum[63:0]);
					end
				endcase
			end
		end
	end

	function automatic logic signed [63:0] asr_f(input logic signed [63:0] v);
		return v >>> FRAC_BITS;
	endfunction

	logic signed [63:0] thr_full, prod_sh, acc_b_cl, acc_s_cl, ps_cl;
	assign thr_full = asr_f(64'(tgain_q) * G055);
	assign prod_sh = asr_f(mul_res);

	function automatic logic signed [63:0] clip_f(input logic signed [63:0] v,
			input logic signed [63:0] lo, input logic signed [63:0] hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction
	assign acc_b_cl = clip_f(acc_b_q, 64'sd0, ONE_Q);
	assign acc_s_cl = clip_f(acc_s_q, -ONE_Q, ONE_Q);
	assign ps_cl    = clip_f(prod_sh, -ONE_Q, ONE_Q);

	assign in_ch.ready   = (state_q == S_IDLE) && !out_valid_q;
	assign out_ch.valid  = out_valid_q;
	assign out_ch.payload = out_q;

	always_comb begin
		raddr = i_q[AW-1:0];
		if (state_q == S_IRD || state_q == S_ICHK)
			raddr = j_q[AW-1:0];
	end

	logic signed [63:0] dden_q;

	always_comb begin
		div_start = 1'b0;
		div_num = w_q;
		div_den = ti_q - dden_q;
		mul_start = 1'b0;
		mul_a = w_q;
		mul_b = t_q - 64'(signed'(rd_t));
		case (state_q)
			S_PDIV: begin
				div_start = 1'b1;
				div_num = 64'(sy_q) <<< FRAC_BITS;
				div_den = 64'(sx_q);
			end
			S_ICHK:   mul_start = (j_q != i_q);
			S_IDIV:   div_start = 1'b1;
			S_PMUL: begin
				mul_start = 1'b1;
				mul_a = 64'(sgain_q);
				mul_b = w_q;
			end
			S_AMUL: begin
				mul_start = 1'b1;
				case (ch_q)
					2'd0:    mul_b = 64'(signed'(rd_th));
					2'd1:    mul_b = 64'(signed'(rd_b));
					default: mul_b = 64'(signed'(rd_s));
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= 1'b0;
			sgain_q     <= 24'sh010000;
			tgain_q     <= 24'sh010000;
			rows_q      <= '0;
			path_seen_q <= 1'b0;
			pvalid_q    <= 1'b0;
			sx_q        <= '0;
			sy_q        <= '0;
			hsteer_q    <= '0;
			hbrake_q    <= '0;
			out_valid_q <= 1'b0;
			fault_q     <= 1'b0;
			out_q       <= '0;
			i_q         <= '0;
			j_q         <= '0;
			ch_q        <= '0;
			w_q         <= '0;
			ti_q        <= '0;
			t_q         <= '0;
			acc_t_q     <= '0;
			acc_b_q     <= '0;
			acc_s_q     <= '0;
			dden_q      <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MODE:  mode_q  <= cfg_data[0];
					REG_SGAIN: sgain_q <= cfg_data;
					REG_TGAIN: tgain_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && out_ch.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						fault_q <= 1'b0;
						case (in_ch.payload.cmd)
							CMD_LOAD:  if (rows_q < CW'(POINTS)) rows_q <= rows_q + CW'(1);
							CMD_PATH: begin
								path_seen_q <= 1'b1;
								pvalid_q <= in_ch.payload.path_has_pose;
								if (in_ch.payload.path_has_pose) begin
									sx_q <= in_ch.payload.point_x;
									sy_q <= in_ch.payload.point_y;
								end
							end
							CMD_CLEAR: rows_q <= '0;
							CMD_TICK: begin
								if (mode_q) begin
									t_q     <= 64'(in_ch.payload.elapsed_seconds) <<< FRAC_BITS;
									acc_t_q <= '0;
									acc_b_q <= '0;
									acc_s_q <= '0;
									i_q     <= '0;
									state_q <= S_IROW;
								end else if (path_seen_q) begin
									state_q <= pvalid_q ? S_PDIV : S_FIN;
								end
							end
							default: ;
						endcase
					end
				end
				S_PDIV: state_q <= S_PWAIT;
				S_PWAIT: if (div_done) begin
					fault_q <= fault_q | div_zero;
					w_q <= div_quo;
					state_q <= S_PMUL;
				end
				S_PMUL: state_q <= S_AACC;
				S_IROW: begin
					if (i_q >= rows_q) state_q <= S_FIN;
					else begin
						w_q <= ONE_Q;
						j_q <= '0;
						state_q <= S_IRD;
					end
				end
				S_IRD: begin
					// rd_t holds t_i here, t_j from the next cycle
					state_q <= S_ICHK;
					ti_q <= 64'(signed'(rd_t));
				end
				S_ICHK: begin
					if (j_q == i_q) begin
						ti_q <= 64'(signed'(rd_t));
						state_q <= S_INEXTJ;
					end else begin
						dden_q <= 64'(signed'(rd_t));
						state_q <= S_IMUL;
					end
				end
				S_IMUL: if (mul_done) begin
					w_q <= mul_res;
					state_q <= S_IDIV;
				end
				S_IDIV: state_q <= S_IDWAIT;
				S_IDWAIT: if (div_done) begin
					fault_q <= fault_q | div_zero;
					w_q <= div_quo;
					state_q <= S_INEXTJ;
				end
				S_INEXTJ: begin
					if (j_q + CW'(1) >= rows_q) begin
						ch_q <= 2'd0;
						state_q <= S_ARD;
					end else begin
						j_q <= j_q + CW'(1);
						state_q <= S_IRD;
					end
				end
				S_ARD: state_q <= S_AMUL;
				S_AMUL: state_q <= S_AACC;
				S_AACC: if (mul_done) begin
					if (!mode_q) begin
						hsteer_q <= ps_cl[17:0];
						state_q <= S_FIN;
					end else begin
						case (ch_q)
							2'd0:    acc_t_q <= sat_add(acc_t_q, prod_sh);
							2'd1:    acc_b_q <= sat_add(acc_b_q, prod_sh);
							default: acc_s_q <= sat_add(acc_s_q, prod_sh);
						endcase
						if (ch_q == 2'd2) begin
							i_q <= i_q + CW'(1);
							state_q <= S_IROW;
						end else begin
							ch_q <= ch_q + 2'd1;
							state_q <= S_AMUL;
						end
					end
				end
				S_FIN: begin
					if (mode_q) begin
						hbrake_q <= acc_b_cl[16:0];
						hsteer_q <= acc_s_cl[17:0];
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					out_q.steering  <= hsteer_q;
					out_q.braking   <= hbrake_q;
					out_q.throttle  <= clip_f(thr_full, 64'sd0, ONE_Q)
						> ONE_Q ? '0 : 17'(clip_f(thr_full, 64'sd0, ONE_Q));
					out_q.div_fault <= fault_q;
					out_valid_q     <= 1'b1;
					state_q         <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	logic unused_sig;
	assign unused_sig = |acc_t_q ^ div_busy;

	`VCG_ASSERT_IMP(a_no_accept_busy, state_q != S_IDLE, !in_ch.ready)
	`VCG_ASSERT_IMP(a_rows_bound, 1'b1, rows_q <= CW'(POINTS))
	`VCG_ASSERT_NEXT(a_out_from_seq, state_q == S_OUT, out_valid_q)
	`VCG_ASSERT_IMP(a_clip_steer, out_valid_q,
		out_q.steering <= 18'sd65536 && out_q.steering >= -18'sd65536)
endmodule
`default_nettype wire

// File: sv/vcg_ram.sv
// generic single-port-write ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module vcg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// File: sv/vcg_divider.sv
// 64-bit signed restoring divider, one quotient bit per cycle
// uses vcg_pkg for saturation constants
`timescale 1ns / 1ps
`default_nettype none
module vcg_divider (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [63:0] num,
	input  wire logic signed [63:0] den,
	output logic                    busy,
	output logic                    done,
	output logic signed [63:0]      quo,
	output logic                    zero_div
);
	import vcg_pkg::*;
	logic [63:0] rem_q, quo_q, den_q;
	logic [6:0]  cnt_q;
	logic        neg_q;
	logic [64:0] trial;
	logic signed [63:0] mag_final;

	assign trial = {rem_q[63:0], quo_q[63]} - {1'b0, den_q};
	// quotient magnitude after the current step
	assign mag_final = trial[64] ? {quo_q[62:0], 1'b0} : {quo_q[62:0], 1'b1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy     <= 1'b0;
			done     <= 1'b0;
			cnt_q    <= '0;
			zero_div <= 1'b0;
			quo      <= '0;
			rem_q    <= '0;
			quo_q    <= '0;
			den_q    <= '0;
			neg_q    <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				zero_div <= 1'b0;
				if (den == '0) begin
					zero_div <= 1'b1;
					done     <= 1'b1;
					quo      <= (num > 0) ? S64_MAX : ((num < 0) ? S64_MIN : '0);
				end else if (num == S64_MIN && den == -64'sd1) begin
					done <= 1'b1;
					quo  <= S64_MAX;
				end else begin
					busy  <= 1'b1;
					cnt_q <= 7'd64;
					rem_q <= '0;
					quo_q <= num[63] ? 64'(-num) : 64'(num);
					den_q <= den[63] ? 64'(-den) : 64'(den);
					neg_q <= num[63] ^ den[63];
				end
			end else if (busy) begin
				if (!trial[64]) begin
					rem_q <= trial[63:0];
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= {rem_q[62:0], quo_q[63]};
					quo_q <= {quo_q[62:0], 1'b0};
				end
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy <= 1'b0;
					done <= 1'b1;
					// quotient sign applied once the loop ends
					quo  <= neg_q ? -mag_final : mag_final;
				end
			end
			if (busy && cnt_q == 7'd0)
				busy <= 1'b0;
		end
	end
endmodule
`default_nettype wire

// File: tb/sv/tb_vehicle_command_generator.sv
// testbench for the vehicle command generator: directed and random command streams
// depends on vcg_pkg, vcg_stream_if and the vehicle_command_generator rtl
`timescale 1ns / 1ps

module tb_vehicle_command_generator;
	import vcg_pkg::*;

	localparam longint ONE_Q     = 64'sd65536;
	localparam longint GAIN_055  = 64'sd36045;
	localparam int     ROW_SLOTS = 16;
	localparam longint LIMIT     = 3000000;

	class command_predictor;
		logic signed [31:0] times_q [ROW_SLOTS];
		logic signed [31:0] thr_q [ROW_SLOTS];
		logic signed [31:0] brk_q [ROW_SLOTS];
		logic signed [31:0] str_q [ROW_SLOTS];
		int                 rows;
		bit                 path_seen;
		bit                 point_valid;
		logic signed [31:0] px, py;
		longint             held_str, held_brk;
		bit                 mode;
		logic signed [23:0] sgain, tgain;
		out_item_t          expected_cmds[$];
		int                 mismatches;

		function new();
			rows = 0; path_seen = 0; point_valid = 0; px = 0; py = 0;
			held_str = 0; held_brk = 0; mode = 0;
			sgain = 24'sd65536; tgain = 24'sd65536; mismatches = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [23:0] data);
			case (idx)
				REG_MODE: mode = data[0];
				REG_SGAIN: sgain = data;
				REG_TGAIN: tgain = data;
				default: ;
			endcase
		endfunction

		function longint mul_sat(longint a, longint b);
			logic signed [127:0] pa, pb, p;
			pa = a; pb = b;
			p = pa * pb;
			if (p > 128'sh7FFF_FFFF_FFFF_FFFF) return S64_MAX;
			if (p < -128'sh8000_0000_0000_0000) return S64_MIN;
			return p[63:0];
		endfunction

		function longint div_sat(longint n, longint d, inout bit fault);
			if (d == 0) begin
				fault = 1;
				return n > 0 ? S64_MAX : (n < 0 ? S64_MIN : 0);
			end
			if (n == S64_MIN && d == -1) return S64_MAX;
			return n / d;
		endfunction

		function longint add_sat(longint a, longint b);
			logic signed [64:0] s;
			s = {a[63], a} + {b[63], b};
			if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return S64_MAX;
			if (s < -65'sh0_8000_0000_0000_0000) return S64_MIN;
			return s[63:0];
		endfunction

		function longint clip(longint v, longint lo, longint hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		function void note_command(in_item_t it);
			bit        fault;
			longint    t, w, acc_b, acc_s, thr, ti, tj, q;
			out_item_t o;
			fault = 0;
			case (it.cmd)
				CMD_LOAD: begin
					if (rows < ROW_SLOTS) begin
						times_q[rows] = it.row_time;
						thr_q[rows] = it.row_throttle;
						brk_q[rows] = it.row_braking;
						str_q[rows] = it.row_steering;
						rows++;
					end
					return;
				end
				CMD_PATH: begin
					path_seen = 1;
					point_valid = it.path_has_pose;
					if (point_valid) begin
						px = it.point_x;
						py = it.point_y;
					end
					return;
				end
				CMD_CLEAR: begin
					rows = 0;
					return;
				end
				default: ;
			endcase
			if (!mode && !path_seen) return;
			if (mode) begin
				t = longint'(it.elapsed_seconds) <<< 16;
				acc_b = 0; acc_s = 0;
				for (int i = 0; i < rows; i++) begin
					ti = times_q[i];
					w = ONE_Q;
					for (int j = 0; j < rows; j++) begin
						if (i != j) begin
							tj = times_q[j];
							w = div_sat(mul_sat(w, t - tj), ti - tj, fault);
						end
					end
					acc_b = add_sat(acc_b, mul_sat(w, longint'(brk_q[i])) >>> 16);
					acc_s = add_sat(acc_s, mul_sat(w, longint'(str_q[i])) >>> 16);
				end
				held_brk = clip(acc_b, 0, ONE_Q);
				held_str = clip(acc_s, -ONE_Q, ONE_Q);
			end else if (point_valid) begin
				q = div_sat(longint'(py) * ONE_Q, longint'(px), fault);
				held_str = clip(mul_sat(longint'(sgain), q) >>> 16, -ONE_Q, ONE_Q);
			end
			thr = clip((longint'(tgain) * GAIN_055) >>> 16, 0, ONE_Q);
			o.steering = held_str[17:0];
			o.throttle = thr[16:0];
			o.braking = held_brk[16:0];
			o.div_fault = fault;
			expected_cmds.insert(expected_cmds.size(), o);
		endfunction

		task report_mismatch(string what, longint got, longint want);
			$display("mismatch %s: got %0d expected %0d", what, got, want);
			mismatches++;
		endtask

		task check_command(out_item_t got);
			out_item_t want;
			if (expected_cmds.size() == 0) begin
				report_mismatch("unexpected command", got.steering, 0);
				return;
			end
			want = expected_cmds.pop_front();
			if (got.steering !== want.steering)
				report_mismatch("steering", got.steering, want.steering);
			if (got.throttle !== want.throttle)
				report_mismatch("throttle", got.throttle, want.throttle);
			if (got.braking !== want.braking)
				report_mismatch("braking", got.braking, want.braking);
			if (got.div_fault !== want.div_fault)
				report_mismatch("div_fault", got.div_fault, want.div_fault);
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [23:0] cfg_data;
	int          max_idle;
	int          stall_left;
	longint      cycles;
	int          big_loads;
	command_predictor pred;

	vcg_stream_if #(.payload_t(in_item_t))  in_ch();
	vcg_stream_if #(.payload_t(out_item_t)) out_ch();

	vehicle_command_generator dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// transaction monitor on both channels, output stall countdown
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				pred.note_command(in_ch.payload);
			if (out_ch.valid && out_ch.ready) begin
				pred.check_command(out_ch.payload);
				stall_left = $urandom_range(0, max_idle);
			end else if (stall_left > 0) begin
				stall_left--;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n)
			out_ch.ready <= 1'b0;
		else
			out_ch.ready <= (stall_left == 0);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// valid stays high straight into the next transaction when no gap is drawn
	task send(in_item_t it);
		int gap;
		gap = $urandom_range(0, max_idle);
		@(negedge clk);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.payload <= it;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	task settle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (pred.expected_cmds.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task write_reg(logic [1:0] idx, logic [23:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		pred.set_reg(idx, data);
	endtask

	function in_item_t noise_item();
		in_item_t it;
		it.cmd = 2'($urandom_range(0, 3));
		it.row_time = $urandom;
		it.row_throttle = $urandom;
		it.row_braking = $urandom;
		it.row_steering = $urandom;
		it.path_has_pose = 1'($urandom_range(0, 1));
		it.point_x = $urandom;
		it.point_y = $urandom;
		it.elapsed_seconds = 16'($urandom_range(0, 65535));
		return it;
	endfunction

	function in_item_t make_cmd(logic [1:0] c);
		in_item_t it;
		it = noise_item();
		it.cmd = c;
		return it;
	endfunction

	task send_row(int sec, bit wild);
		in_item_t it;
		it = make_cmd(CMD_LOAD);
		if (!wild) begin
			it.row_time = sec <<< 16;
			it.row_throttle = int'($urandom_range(0, 196608)) - 98304;
			it.row_braking = int'($urandom_range(0, 196608)) - 98304;
			it.row_steering = int'($urandom_range(0, 196608)) - 98304;
		end
		send(it);
	endtask

	task send_tick(int sec);
		in_item_t it;
		it = make_cmd(CMD_TICK);
		it.elapsed_seconds = 16'(sec);
		send(it);
	endtask

	task send_path(bit pose, logic signed [31:0] x, logic signed [31:0] y);
		in_item_t it;
		it = make_cmd(CMD_PATH);
		it.path_has_pose = pose;
		it.point_x = x;
		it.point_y = y;
		send(it);
	endtask

	task random_phase(int items);
		int done, kind, n, base;
		in_item_t it;
		done = 0;
		while (done < items) begin
			kind = $urandom_range(0, 9);
			if (kind <= 5) begin
				n = $urandom_range(1, 4);
				base = $urandom_range(0, 20);
				send(make_cmd(CMD_CLEAR));
				for (int k = 0; k < n; k++)
					// an occasional repeated time forces a zero divisor
					send_row(($urandom_range(0, 9) == 0) ? base : base + k, 0);
				for (int k = $urandom_range(1, 3); k > 0; k--)
					send_tick(base + $urandom_range(0, n + 2));
				done += n + 3;
			end else if (kind <= 7) begin
				it = make_cmd(CMD_PATH);
				if ($urandom_range(0, 4) == 0) it.point_x = 0;
				send(it);
				send_tick($urandom_range(0, 65535));
				done += 2;
			end else if (kind == 8 || big_loads >= 2) begin
				send(noise_item());
				done++;
			end else begin
				big_loads++;
				send(make_cmd(CMD_CLEAR));
				for (int k = 0; k <= ROW_SLOTS; k++)
					send_row(0, 1);
				send_tick($urandom_range(0, 65535));
				done += ROW_SLOTS + 3;
			end
		end
		settle();
	endtask

	initial begin
		pred = new();
		big_loads = 0;
		max_idle = 5;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_MODE;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.payload = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// path mode: tick before any path, then the path corner cases
		send_tick(0);
		send_path(0, 0, 0);
		send_tick(1);
		send_path(1, 32'sd65536, 32'sd32768);
		send_tick(2);
		send_path(1, 0, 32'sd100);
		send_tick(3);
		send_path(1, 0, -32'sd100);
		send_tick(4);
		send_path(1, 0, 0);
		send_tick(5);
		send_path(1, -32'sd1, 32'h8000_0000);
		send_tick(65535);
		send_path(0, 0, 0);
		send_tick(6);
		settle();

		// recorded mode: no rows, equal times, then an overfull store
		write_reg(REG_MODE, 24'd1);
		write_reg(REG_TGAIN, 24'h7FFFFF);
		send(make_cmd(CMD_CLEAR));
		send_tick(0);
		send_row(3, 0);
		send_row(3, 0);
		send_tick(3);
		send(make_cmd(CMD_CLEAR));
		for (int k = 0; k <= ROW_SLOTS; k++)
			send_row(k, 0);
		send_tick(7);
		settle();

		write_reg(REG_MODE, 24'd0);
		write_reg(REG_SGAIN, 24'h7FFFFF);
		write_reg(REG_TGAIN, 24'h800000);
		random_phase(15);

		max_idle = 0;
		write_reg(REG_SGAIN, 24'h800000);
		write_reg(REG_TGAIN, 24'($urandom));
		random_phase(15);

		max_idle = 5;
		write_reg(REG_MODE, 24'd1);
		write_reg(REG_SGAIN, 24'($urandom));
		write_reg(REG_TGAIN, 24'd65536);
		random_phase(15);

		max_idle = 0;
		write_reg(REG_TGAIN, 24'd0);
		random_phase(15);

		if (pred.mismatches == 0 && pred.expected_cmds.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
